// ===== sv/alkd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alkd_pkg
// Shared types, constants and the ladder window classifier for the keypad
// decoder.
// ----------------------------------------------------------------------------
package alkd_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int BUTTON_W   = 4;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int S_TDATA_W  = 48;  // sample + now_ms, padded to bytes
  localparam int M_TDATA_W  = 8;   // pressed + button + long_press, padded

  localparam int QUEUE_DEPTH_DEF = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LONG_CLICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 2'd2;

  localparam logic [CFG_W-1:0] LONG_CLICK_RST = 16'd700;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd600;
  localparam logic [CFG_W-1:0] RELEASE_RST    = 16'd200;

  // Lowest reading that counts as a key being down
  localparam logic [SAMPLE_W-1:0] HIGH_LEVEL = 10'd472;

  // Classified beat handed from front to back
  typedef struct packed {
    logic                high;  // reading at or above the press level
    logic                hit;   // reading falls in a button window
    logic [BUTTON_W-1:0] id;    // button index, zero on a gap
    logic [TIME_W-1:0]   now;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_click_ms;
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] release_ms;
  } cfg_t;

  typedef struct packed {
    logic                hit;
    logic [BUTTON_W-1:0] id;
  } class_t;

  // Windows are tested in priority order, first match wins
  function automatic class_t classify(input logic [SAMPLE_W-1:0] s);
    class_t c;
    c.hit = 1'b1;
    c.id  = '0;
    if (s >= 10'd981)                      c.id = 4'd1;
    else if (s >= 10'd894 && s <= 10'd966) c.id = 4'd2;
    else if (s >= 10'd823 && s <= 10'd876) c.id = 4'd3;
    else if (s >= 10'd763 && s <= 10'd817) c.id = 4'd4;
    else if (s >= 10'd707 && s <= 10'd753) c.id = 4'd5;
    else if (s >= 10'd662 && s <= 10'd698) c.id = 4'd6;
    else if (s >= 10'd622 && s <= 10'd698) c.id = 4'd7;
    else if (s >= 10'd586 && s <= 10'd614) c.id = 4'd8;
    else if (s >= 10'd556 && s <= 10'd584) c.id = 4'd9;
    else if (s >= 10'd526 && s <= 10'd554) c.id = 4'd10;
    else if (s >= 10'd501 && s <= 10'd519) c.id = 4'd0;
    else if (s >= 10'd472 && s <= 10'd508) c.id = 4'd11;
    else                                   c.hit = 1'b0;
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/alkd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alkd_front
// Input stage: takes sample beats, classifies the reading and pushes the
// classified beat into the queue.
// ----------------------------------------------------------------------------
module alkd_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [alkd_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                                 push,
  output alkd_pkg::item_t                      push_item,
  input  wire logic                            q_full
);
  import alkd_pkg::*;

  logic   held;
  item_t  item;
  class_t cls;
  logic [SAMPLE_W-1:0] sample;

  assign sample    = s_tdata[SAMPLE_W-1:0];
  assign cls       = classify(sample);
  assign push      = held && !q_full;
  assign push_item = item;
  assign s_tready  = !held || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.high <= (sample >= HIGH_LEVEL);
      item.hit  <= (sample >= HIGH_LEVEL) && cls.hit;
      item.id   <= (sample >= HIGH_LEVEL) ? cls.id : '0;
      item.now  <= s_tdata[SAMPLE_W +: TIME_W];
    end
  end

endmodule
`default_nettype wire

// ===== sv/alkd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alkd_queue
// Short FIFO of classified beats between front and back.
// ----------------------------------------------------------------------------
module alkd_queue #(
  parameter int QUEUE_DEPTH = alkd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  alkd_pkg::item_t      push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output alkd_pkg::item_t      head
);
  import alkd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

// ===== sv/alkd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alkd_back
// Debounce / long-press state and the output register.
// ----------------------------------------------------------------------------
module alkd_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  alkd_pkg::cfg_t                       cfg,
  input  wire logic                            q_not_empty,
  input  alkd_pkg::item_t                      head,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [alkd_pkg::M_TDATA_W-1:0]       m_tdata
);
  import alkd_pkg::*;

  logic                last_button_valid, last_button_valid_next;
  logic [BUTTON_W-1:0] last_button_id, last_button_id_next;
  logic [TIME_W-1:0]   last_click_time, last_click_time_next;
  logic [TIME_W-1:0]   last_press_time, last_press_time_next;

  logic                pressed, long_press;
  logic [BUTTON_W-1:0] button;
  logic [TIME_W-1:0]   since_click, since_press;
  logic                same;

  assign pop = q_not_empty && (!m_tvalid || m_tready);

  always_comb begin
    last_button_valid_next = last_button_valid;
    last_button_id_next    = last_button_id;
    last_click_time_next   = last_click_time;
    last_press_time_next   = last_press_time;
    pressed     = 1'b0;
    long_press  = 1'b0;
    button      = '0;
    since_click = head.now - last_click_time;
    since_press = head.now - last_press_time;
    same        = (head.hit == last_button_valid) &&
                  (!head.hit || head.id == last_button_id);
    if (head.high) begin
      last_press_time_next = head.now;
      if (!same) begin
        if (since_click > TIME_W'(cfg.debounce_ms)) begin
          last_click_time_next   = head.now;
          last_button_valid_next = head.hit;
          last_button_id_next    = head.id;
          pressed = head.hit;
          button  = head.hit ? head.id : '0;
        end
      end else if (since_click > TIME_W'(cfg.long_click_ms)) begin
        last_click_time_next = head.now;
        // a held gap never reports
        pressed    = head.hit;
        long_press = head.hit;
        button     = head.hit ? head.id : '0;
      end
    end else if (since_press > TIME_W'(cfg.release_ms)) begin
      last_button_valid_next = 1'b0;
      last_button_id_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_button_valid <= 1'b0;
      last_button_id    <= '0;
      last_click_time   <= '0;
      last_press_time   <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      if (pop) begin
        last_button_valid <= last_button_valid_next;
        last_button_id    <= last_button_id_next;
        last_click_time   <= last_click_time_next;
        last_press_time   <= last_press_time_next;
        m_tvalid          <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {{(M_TDATA_W - BUTTON_W - 2){1'b0}}, long_press, button, pressed};
    end
  end

endmodule
`default_nettype wire

// ===== sv/analog_ladder_keypad_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// analog_ladder_keypad_decoder
// Resistor-ladder keypad decoder with debounce, long press and release.
// ----------------------------------------------------------------------------
// Each input beat carries one 10-bit converter reading of the keypad ladder
// and the millisecond time it was taken; each beat gives exactly one output
// beat. A reading of 472 or more is matched against twelve fixed windows in
// priority order; a reading between windows counts as no button. A change of
// button is reported once more than debounce_ms have passed since the last
// accepted click, a button still held after more than long_click_ms is
// reported again with long_press set, and a low reading more than release_ms
// after the last high one clears the held button. All time differences wrap
// modulo 2^32. It takes one beat per clock while the queue has room; a beat
// passes the input register, queue and output register. The front stage
// classifies and the back stage holds the timing state; a QUEUE_DEPTH-entry
// queue between them lets either side stall without stopping the other.
// Configuration registers (cfg_index): 0 long_click_ms (reset 700),
// 1 debounce_ms (reset 600), 2 release_ms (reset 200); index 3 is ignored.
// Write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module analog_ladder_keypad_decoder #(
  parameter int QUEUE_DEPTH = alkd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [9:0] sample, [41:10] now_ms, [47:42] zero
  input  wire logic [alkd_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [0] pressed, [4:1] button, [5] long_press, [7:6] zero
  output logic [alkd_pkg::M_TDATA_W-1:0]       m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [alkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [alkd_pkg::CFG_W-1:0]      cfg_data
);
  import alkd_pkg::*;

  cfg_t  cfg;
  item_t push_item, head;
  logic  push, q_full, q_not_empty, pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_click_ms <= LONG_CLICK_RST;
      cfg.debounce_ms   <= DEBOUNCE_RST;
      cfg.release_ms    <= RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_CLICK: cfg.long_click_ms <= cfg_data;
        REG_DEBOUNCE:   cfg.debounce_ms   <= cfg_data;
        REG_RELEASE:    cfg.release_ms    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Front: input register and window classifier
  alkd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // Queue between the two halves
  alkd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // Back: debounce / long-press state and output register
  alkd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the resistor-ladder keypad decoder.
// ----------------------------------------------------------------------------
// A queue of readings (converter sample plus millisecond stamp) feeds a
// clocked driver. Each accepted beat goes through a local model of the
// window match, debounce, long-press and release timing, and the expected
// result beat is queued. A clocked monitor pops and compares every result
// beat field by field. Both sides stall at random. The register settings
// are changed between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module tb;

  import alkd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // not mapped, ignored

  typedef struct packed {
    logic [SAMPLE_W-1:0] rd;
    logic [TIME_W-1:0]   at;
  } reading_t;

  typedef struct packed {
    logic                pressed;
    logic [BUTTON_W-1:0] button;
    logic                long_press;
  } click_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  analog_ladder_keypad_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local model of the decoder: register mirror and timing state
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]    long_ms   = LONG_CLICK_RST;
  logic [CFG_W-1:0]    settle_ms = DEBOUNCE_RST;
  logic [CFG_W-1:0]    rel_ms    = RELEASE_RST;
  logic                held_ok   = 1'b0;
  logic [BUTTON_W-1:0] held_id   = '0;
  logic [TIME_W-1:0]   click_at  = '0;
  logic [TIME_W-1:0]   press_at  = '0;

  // Ladder windows by priority rank; rank 0 wins over every later one
  function automatic void window(input int rank, output int lo, output int hi,
                                 output int id);
    case (rank)
      0:       begin lo = 981; hi = 1023; id = 1;  end
      1:       begin lo = 894; hi = 966;  id = 2;  end
      2:       begin lo = 823; hi = 876;  id = 3;  end
      3:       begin lo = 763; hi = 817;  id = 4;  end
      4:       begin lo = 707; hi = 753;  id = 5;  end
      5:       begin lo = 662; hi = 698;  id = 6;  end
      6:       begin lo = 622; hi = 698;  id = 7;  end
      7:       begin lo = 586; hi = 614;  id = 8;  end
      8:       begin lo = 556; hi = 584;  id = 9;  end
      9:       begin lo = 526; hi = 554;  id = 10; end
      10:      begin lo = 501; hi = 519;  id = 0;  end
      default: begin lo = 472; hi = 508;  id = 11; end
    endcase
  endfunction

  // -1 for a reading between windows
  function automatic int button_of(input logic [SAMPLE_W-1:0] rd);
    int lo, hi, id;
    for (int r = 0; r < 12; r++) begin
      window(r, lo, hi, id);
      if (rd >= lo && rd <= hi) return id;
    end
    return -1;
  endfunction

  // One reading in, one result out; updates the timing state
  function automatic click_t decode_beat(input logic [SAMPLE_W-1:0] rd,
                                         input logic [TIME_W-1:0] at);
    click_t              c;
    int                  b;
    logic                hit;
    logic [BUTTON_W-1:0] id;
    logic [TIME_W-1:0]   gone;
    c = '0;
    if (rd >= HIGH_LEVEL) begin
      b    = button_of(rd);
      hit  = (b >= 0);
      id   = hit ? 4'(b) : 4'd0;
      gone = at - click_at;
      press_at = at;
      if (hit != held_ok || (hit && id != held_id)) begin
        // change of button (or to/from a gap): only after the debounce time
        if (gone > settle_ms) begin
          click_at = at;
          held_ok  = hit;
          held_id  = id;
          c.pressed = hit;
          c.button  = id;
        end
      end else if (gone > long_ms) begin
        // same button held: long press; a held gap only restarts the timing
        click_at     = at;
        c.pressed    = hit;
        c.button     = id;
        c.long_press = hit;
      end
    end else if (at - press_at > rel_ms) begin
      held_ok = 1'b0;
      held_id = '0;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Queues, counters, reporting
  // --------------------------------------------------------------------------
  reading_t    readings [$];   // waiting to be driven
  click_t      clicks_due [$]; // predicted, not yet seen
  reading_t    cur;
  logic        calm = 1'b0;    // no stalls on either side while set
  int unsigned queued = 0, sent = 0, checked = 0, mismatches = 0;
  int unsigned clicks_seen = 0, longs_seen = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  task automatic flag(input string what);
    mismatches++;
    $display("ERROR %0t: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Driver: holds a beat until taken; once it is taken, valid may drop at random in the next cycle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        clicks_due.push_back(decode_beat(cur.rd, cur.at));
        sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (readings.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
          cur = readings.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, cur.at, cur.rd};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, compare each result beat with the oldest
  // prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    click_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.pressed    = m_tdata[0];
        got.button     = m_tdata[4:1];
        got.long_press = m_tdata[5];
        if (clicks_due.size() == 0) begin
          flag($sformatf("result beat with nothing expected (data %h)", m_tdata));
        end else begin
          want = clicks_due.pop_front();
          checked++;
          if (got.pressed != want.pressed)
            flag($sformatf("beat %0d pressed: got %0b, want %0b",
                           checked, got.pressed, want.pressed));
          if (got.button != want.button)
            flag($sformatf("beat %0d button: got %0d, want %0d",
                           checked, got.button, want.button));
          if (got.long_press != want.long_press)
            flag($sformatf("beat %0d long_press: got %0b, want %0b",
                           checked, got.long_press, want.long_press));
          if (want.pressed) clicks_seen++;
          if (want.long_press) longs_seen++;
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_at(input logic [SAMPLE_W-1:0] rd, input logic [TIME_W-1:0] at);
    reading_t r;
    r.rd = rd;
    r.at = at;
    clock_ms = at;
    readings.push_back(r);
    queued++;
  endtask

  task automatic add_reading(input logic [SAMPLE_W-1:0] rd, input int span);
    push_at(rd, clock_ms + $urandom_range(span, 0));
  endtask

  function automatic logic [SAMPLE_W-1:0] gap_reading();
    logic [SAMPLE_W-1:0] rd;
    do rd = SAMPLE_W'($urandom_range(1023, 472)); while (button_of(rd) >= 0);
    return rd;
  endfunction

  // A press: readings inside one window with the odd bounce or gap,
  // then a few low readings
  task automatic add_session(input int span);
    int lo, hi, id, hold, tail;
    window($urandom_range(11), lo, hi, id);
    hold = $urandom_range(12, 1);
    tail = $urandom_range(4, 1);
    for (int n = 0; n < hold; n++) begin
      case ($urandom_range(19))
        0:       add_reading(gap_reading(), span);
        1:       add_reading(SAMPLE_W'($urandom_range(1023, 0)), span);
        default: add_reading(SAMPLE_W'($urandom_range(hi, lo)), span);
      endcase
    end
    for (int n = 0; n < tail; n++) add_reading(SAMPLE_W'($urandom_range(471, 0)), span);
  endtask

  // Any reading, sometimes at an arbitrary time stamp
  task automatic add_noise(input int span);
    if ($urandom_range(3) == 0) push_at(SAMPLE_W'($urandom_range(1023, 0)), $urandom);
    else add_reading(SAMPLE_W'($urandom_range(1023, 0)), span);
  endtask

  task automatic run_phase(input int count, input int span);
    int unsigned stop;
    stop = queued + count;
    while (queued < stop) begin
      if ($urandom_range(9) < 8) add_session(span);
      else add_noise(span);
    end
  endtask

  // Waits until every reading is sent and every predicted result has come back,
  // then lets the pipeline settle before the next step
  task automatic drain();
    @(negedge clk);
    while (readings.size() != 0 || s_tvalid || clicks_due.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LONG_CLICK: long_ms   = val;
      REG_DEBOUNCE:   settle_ms = val;
      REG_RELEASE:    rel_ms    = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [CFG_W-1:0] lc, input logic [CFG_W-1:0] db,
                         input logic [CFG_W-1:0] rl);
    write_reg(REG_LONG_CLICK, lc);
    write_reg(REG_DEBOUNCE, db);
    write_reg(REG_RELEASE, rl);
    write_reg(REG_SPARE, CFG_W'($urandom));
  endtask

  // Window edges; consecutive entries mostly change button
  int ladder_marks [0:17] = '{1023, 966, 894, 876, 823, 817, 763, 753, 707,
                              698, 661, 614, 586, 556, 526, 519, 501, 472};

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset register values (700 / 600 / 200)
    clock_ms = 32'd1000;
    foreach (ladder_marks[k]) add_reading(SAMPLE_W'(ladder_marks[k]), 0) ;
    for (int k = 0; k < readings.size(); k++)
      readings[k].at = 32'd1000 + 601 * k;
    clock_ms = readings[readings.size() - 1].at;
    add_reading(10'd970, 0);               // gap drops the held button
    clock_ms += 601; readings[readings.size() - 1].at = clock_ms;
    push_at(10'd970, clock_ms + 701);      // held gap: no false long press
    push_at(10'd0, clock_ms + 50);         // low, too soon for release
    push_at(10'd471, clock_ms + 300);      // release
    push_at(10'd1023, 32'hFFFF_FF00);
    push_at(10'd1023, 32'h0000_0200);      // long press across the wrap
    push_at(10'd0, 32'hFFFF_FFFF);         // release, difference wraps
    drain();

    run_phase(170, 400);
    drain();

    // Everything zero: any nonzero gap in time counts
    set_all(16'd0, 16'd0, 16'd0);
    run_phase(170, 20);
    drain();

    // Everything at its top value, with long steps in time
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(170, 50000);
    drain();

    // No stalls on either side for this stretch
    calm = 1'b1;
    set_all(CFG_W'($urandom_range(1000, 0)), CFG_W'($urandom_range(1000, 0)),
            CFG_W'($urandom_range(1000, 0)));
    run_phase(170, 600);
    drain();
    calm = 1'b0;

    set_all(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    run_phase(170, 40000);
    drain();

    if (clicks_due.size() != 0) flag("predicted results left over at the end");
    $display("summary: %0d readings sent, %0d results checked, %0d clicks, %0d long",
             sent, checked, clicks_seen, longs_seen);
    $display("summary: register sets: reset, all zero, all ones, two random; %0d errors",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
